[hdl/ydec_pkg.sv]
// Package: shared types, constants and the CRC-32 byte update for the yEnc body decoder.
`timescale 1ns / 1ps
`default_nettype none
package ydec_pkg;

   // Byte counter width; the reported count is the low 32 bits.
   localparam int COUNT_BITS = 32;

   // Result queue depth.
   localparam int RSP_DEPTH  = 2;
   localparam int RSP_PTR_W  = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   // Request kinds carried in the op field.
   localparam logic [1:0] OP_DATA = 2'd0;
   localparam logic [1:0] OP_EOL  = 2'd1;
   localparam logic [1:0] OP_PART = 2'd2;

   // Error codes.
   localparam logic ERR_NONE    = 1'b0;
   localparam logic ERR_ESC_EOL = 1'b1;

   // yEnc characters and offsets.
   localparam logic [7:0] CHAR_DOT      = 8'h2e;
   localparam logic [7:0] CHAR_ESCAPE   = 8'h3d;
   localparam logic [7:0] CHAR_NUL      = 8'h00;
   localparam logic [7:0] PLAIN_OFFSET  = 8'd42;
   localparam logic [7:0] ESCAPE_OFFSET = 8'd106;
   localparam logic [7:0] DOT_DECODED   = 8'(CHAR_DOT - PLAIN_OFFSET);

   localparam logic [31:0] CRC_POLY = 32'hedb88320;
   localparam logic [31:0] CRC_INIT = 32'hffffffff;

   localparam logic [1:0] LINE_POS_MAX = 2'd3;

   // Payload width of the result channel, rounded up to whole bytes.
   localparam int RSP_FIELD_BITS = 1 + 8 + 32 + 32 + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // CSR map
   localparam int          CSR_ADDR_BITS   = 3;
   localparam logic        CSR_IDX_DOT_FIX = 1'b0;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] in_byte;
   } req_item_type;

   typedef struct packed {
      logic        out_valid;
      logic [7:0]  out_byte;
      logic [31:0] crc_value;
      logic [31:0] decoded_count;
      logic        error_code;
      logic        last;
   } rsp_item_type;

   // Reflected CRC-32, one byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h000000, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[hdl/yenc_body_decoder_crc32.sv]
// Top level: yEnc body decoder with running CRC-32, stream ports and CSR port.
// Requests pass the input register, the combinational decode core and the result queue.
// Throughput: one request per cycle while the result queue has room; a data byte other than
//   a dot after a held leading dot goes on a later pass; the core emits one result per cycle.
// Reset (synchronous, active high): CRC all ones, count zero, line state cleared,
//   dot fix disabled, input register and result queue empty.
`timescale 1ns / 1ps
`default_nettype none
module yenc_body_decoder_crc32
   import ydec_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,   // [7:0] in_byte
   input  wire logic [1:0]                 req_tuser,   // [1:0] op
   // result channel
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [RSP_DATA_BITS-1:0]        rsp_tdata,   // [0] out_valid, [8:1] out_byte,
                                                        // [40:9] crc_value,
                                                        // [72:41] decoded_count,
                                                        // [73] error_code, rest zero
   output logic                            rsp_tlast,   // last
   // CSR port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   // CSR: single register, dot fix enable at byte address 0
   logic dot_fix_ff;
   logic csr_write;
   logic csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_BITS-1] == CSR_IDX_DOT_FIX);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {31'd0, dot_fix_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_fix_ff <= 1'b0;
      end else if (csr_write && csr_hit) begin
         dot_fix_ff <= csr_pwdata[0];
      end
   end

   // Input register: holds one request until the core takes it.
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         consume;
   logic         req_take;

   assign req_tready = !in_valid_ff || consume;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{op: req_tuser, in_byte: req_tdata};
      end
   end

   // Decode core
   logic         rsp_room;
   logic         rsp_push;
   rsp_item_type core_item;

   ydec_core u_core (
      .clock          (clock),
      .reset          (reset),
      .dot_fix_enable (dot_fix_ff),
      .item_valid     (in_valid_ff),
      .item           (in_item_ff),
      .rsp_room       (rsp_room),
      .item_consume   (consume),
      .rsp_push       (rsp_push),
      .rsp_item       (core_item)
   );

   // Result queue feeding the output channel
   rsp_item_type q_item;

   ydec_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (core_item),
      .room      (rsp_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (q_item)
   );

   assign rsp_tdata = RSP_DATA_BITS'({q_item.error_code, q_item.decoded_count,
                                      q_item.crc_value, q_item.out_byte,
                                      q_item.out_valid});
   assign rsp_tlast = q_item.last;

endmodule
`default_nettype wire

[hdl/ydec_core.sv]
// Core: line state, escapes, CRC and byte count; one result per cycle with queue room.
`timescale 1ns / 1ps
`default_nettype none
module ydec_core
   import ydec_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         dot_fix_enable,
   input  wire logic         item_valid,
   input  req_item_type      item,
   input  wire logic         rsp_room,
   output logic              item_consume,
   output logic              rsp_push,
   output rsp_item_type      rsp_item
);

   logic [31:0]           crc_ff, crc_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  esc_ff, esc_in;
   logic [1:0]            line_pos_ff, line_pos_in;
   logic                  held_ff, held_in;
   logic                  discard_ff, discard_in;

   logic       emit;
   logic [7:0] emit_val;
   logic       err;
   logic       last;

   always_comb begin
      crc_in       = crc_ff;
      count_in     = count_ff;
      esc_in       = esc_ff;
      line_pos_in  = line_pos_ff;
      held_in      = held_ff;
      discard_in   = discard_ff;
      emit         = 1'b0;
      emit_val     = DOT_DECODED;
      err          = 1'b0;
      last         = 1'b1;
      item_consume = 1'b0;

      if (item_valid && rsp_room) begin
         case (item.op)
            OP_DATA: begin
               if (discard_ff) begin
                  item_consume = 1'b1;
               end else if (held_ff && item.in_byte != CHAR_DOT) begin
                  // flush the held dot first; the byte itself goes on the next pass
                  // a zero byte or an escape gives nothing more, so the dot is last
                  emit    = 1'b1;
                  last    = (item.in_byte == CHAR_NUL) || (item.in_byte == CHAR_ESCAPE);
                  held_in = 1'b0;
               end else if (!held_ff && line_pos_ff == 2'd0 && dot_fix_enable &&
                            item.in_byte == CHAR_DOT && !esc_ff) begin
                  held_in      = 1'b1;
                  line_pos_in  = 2'd1;
                  item_consume = 1'b1;
               end else begin
                  held_in      = 1'b0;
                  item_consume = 1'b1;
                  if (line_pos_ff != LINE_POS_MAX) begin
                     line_pos_in = line_pos_ff + 2'd1;
                  end
                  if (item.in_byte == CHAR_NUL) begin
                     err        = esc_ff;
                     esc_in     = 1'b0;
                     discard_in = 1'b1;
                  end else if (esc_ff) begin
                     esc_in   = 1'b0;
                     emit     = 1'b1;
                     emit_val = 8'(item.in_byte - ESCAPE_OFFSET);
                  end else if (item.in_byte == CHAR_ESCAPE) begin
                     esc_in = 1'b1;
                  end else begin
                     emit     = 1'b1;
                     emit_val = 8'(item.in_byte - PLAIN_OFFSET);
                  end
               end
            end
            OP_EOL: begin
               if (held_ff) begin
                  emit         = 1'b1;
                  held_in      = 1'b0;
                  last         = !esc_ff;
                  item_consume = !esc_ff;
               end else begin
                  err          = esc_ff;
                  esc_in       = 1'b0;
                  line_pos_in  = 2'd0;
                  discard_in   = 1'b0;
                  item_consume = 1'b1;
               end
               if (!esc_ff) begin
                  line_pos_in = 2'd0;
                  discard_in  = 1'b0;
               end
            end
            OP_PART: begin
               crc_in       = CRC_INIT;
               count_in     = '0;
               esc_in       = 1'b0;
               line_pos_in  = 2'd0;
               held_in      = 1'b0;
               discard_in   = 1'b0;
               item_consume = 1'b1;
            end
            default: begin
               item_consume = 1'b1;
            end
         endcase
      end

      if (emit) begin
         crc_in = crc_byte(crc_ff, emit_val);
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end

      rsp_push                = emit || err;
      rsp_item.out_valid      = emit;
      rsp_item.out_byte       = emit ? emit_val : 8'h00;
      rsp_item.crc_value      = crc_in;
      rsp_item.decoded_count  = 32'(count_in);
      rsp_item.error_code     = err ? ERR_ESC_EOL : ERR_NONE;
      rsp_item.last           = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= CRC_INIT;
         count_ff    <= '0;
         esc_ff      <= 1'b0;
         line_pos_ff <= 2'd0;
         held_ff     <= 1'b0;
         discard_ff  <= 1'b0;
      end else begin
         crc_ff      <= crc_in;
         count_ff    <= count_in;
         esc_ff      <= esc_in;
         line_pos_ff <= line_pos_in;
         held_ff     <= held_in;
         discard_ff  <= discard_in;
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> rsp_room) else $error("result pushed without queue room");
   a_consume_valid: assert property (@(posedge clock) disable iff (reset)
      item_consume |-> item_valid) else $error("request consumed while none held");
   a_held_no_esc: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> (!esc_ff && !discard_ff)) else $error("held dot alongside escape/discard");
   a_flush_then_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && !rsp_item.last) |=> (item_valid && !held_ff))
      else $error("dot flush not followed by its request");

endmodule
`default_nettype wire

[hdl/ydec_rsp_queue.sv]
// Small result queue that decouples the decode core from the result channel.
`timescale 1ns / 1ps
`default_nettype none
module ydec_rsp_queue
   import ydec_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  rsp_item_type      push_item,
   output logic              room,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_item_type      out_item
);

   rsp_item_type           entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign room      = (count_ff != RSP_CNT_W'(RSP_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> room) else $error("push into full result queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH)) else $error("result queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("result queue count missed a push");

endmodule
`default_nettype wire

[sim/yenc_body_decoder_crc32_tb.sv]
// Self-checking testbench for the yEnc body decoder with running CRC-32.
`timescale 1ns / 1ps
module yenc_body_decoder_crc32_tb;
   import ydec_pkg::*;

   // Timing and run shape.
   localparam int HOLD_CYCLES    = 300;   // one long receiver hold-off
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either side
   localparam int SETTLE_CYCLES  = 8;     // covers requests still in flight with no result
   localparam int IDLE_PCT       = 32;
   localparam int PHASE_ITEMS    = 250;
   localparam int SHOWN_ERRORS   = 50;

   // op value that the decoder ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] DOT_FIX_ADDR = CSR_ADDR_BITS'(4 * CSR_IDX_DOT_FIX);

   // Opening directed requests, {op, in_byte}; run with the dot fix on.
   localparam logic [9:0] OPENING [27] = '{
      // offset wrap at both ends, CR and LF as plain data
      {OP_DATA, 8'h2a}, {OP_DATA, 8'hff}, {OP_DATA, 8'h0a}, {OP_DATA, 8'h0d}, {OP_EOL, 8'h00},
      // ".." at line start: first dot dropped
      {OP_DATA, CHAR_DOT}, {OP_DATA, CHAR_DOT}, {OP_EOL, 8'hff},
      // held dot then another byte: two results from one request
      {OP_DATA, CHAR_DOT}, {OP_DATA, 8'h62}, {OP_EOL, 8'h00},
      // held dot flushed by end of line
      {OP_DATA, CHAR_DOT}, {OP_EOL, 8'h00},
      // escaped byte with wrap, then escape left pending at end of line
      {OP_DATA, CHAR_ESCAPE}, {OP_DATA, 8'h40}, {OP_DATA, CHAR_ESCAPE}, {OP_EOL, 8'h00},
      // zero right after escape, rest of line discarded
      {OP_DATA, CHAR_ESCAPE}, {OP_DATA, CHAR_NUL}, {OP_DATA, 8'h41}, {OP_EOL, 8'h00},
      // held dot flushed by a zero byte, rest of line discarded
      {OP_DATA, CHAR_DOT}, {OP_DATA, CHAR_NUL}, {OP_DATA, 8'h42}, {OP_EOL, 8'h00},
      // ignored op, then a new part
      {OP_UNUSED, 8'hff}, {OP_PART, 8'h00}
   };

   // Tracks decoder state, predicts decoded bytes and checks them in order.
   class yenc_crc_tracker;
      rsp_item_type          due_decodes[$];
      logic [31:0]           crc;
      logic [COUNT_BITS-1:0] count;
      logic [1:0]            line_pos;
      bit                    esc_pending;
      bit                    held_dot;
      bit                    discard;
      bit                    dot_fix;
      int                    errors;
      int                    requests;
      int                    results;
      int                    flagged;
      int                    pairs;

      function new();
         crc     = CRC_INIT;
         count   = '0;
         dot_fix = 1'b0;
         clear_line();
      endfunction

      function void clear_line();
         esc_pending = 1'b0;
         held_dot    = 1'b0;
         discard     = 1'b0;
         line_pos    = 2'd0;
      endfunction

      // reflected CRC-32, LSB first
      function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
         logic [31:0] acc;
         acc = c ^ {24'd0, b};
         repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
         return acc;
      endfunction

      function void emit(logic [7:0] b);
         rsp_item_type r;
         crc = crc_next(crc, b);
         if (count != '1) count++;
         r               = '0;
         r.out_valid     = 1'b1;
         r.out_byte      = b;
         r.crc_value     = crc;
         r.decoded_count = 32'(count);
         r.error_code    = ERR_NONE;
         due_decodes.push_back(r);
      endfunction

      function void flag_escape_error();
         rsp_item_type r;
         r               = '0;
         r.crc_value     = crc;
         r.decoded_count = 32'(count);
         r.error_code    = ERR_ESC_EOL;
         due_decodes.push_back(r);
      endfunction

      function void decode_byte(logic [7:0] b);
         if (line_pos != LINE_POS_MAX) line_pos++;
         if (b == CHAR_NUL) begin
            if (esc_pending) begin
               esc_pending = 1'b0;
               flag_escape_error();
            end
            discard = 1'b1;
         end else if (esc_pending) begin
            esc_pending = 1'b0;
            emit(b - ESCAPE_OFFSET);
         end else if (b == CHAR_ESCAPE) begin
            esc_pending = 1'b1;
         end else begin
            emit(b - PLAIN_OFFSET);
         end
      endfunction

      function void absorb_request(logic [1:0] op, logic [7:0] b);
         int first;
         first = due_decodes.size();
         requests++;
         case (op)
            OP_DATA: begin
               if (discard) begin
                  // rest of line dropped after a zero byte
               end else if (held_dot) begin
                  held_dot = 1'b0;
                  if (b != CHAR_DOT) emit(DOT_DECODED);
                  decode_byte(b);
               end else if (line_pos == 2'd0 && dot_fix && b == CHAR_DOT && !esc_pending) begin
                  held_dot = 1'b1;
                  line_pos = 2'd1;
               end else begin
                  decode_byte(b);
               end
            end
            OP_EOL: begin
               if (held_dot) emit(DOT_DECODED);
               if (esc_pending) flag_escape_error();
               clear_line();
            end
            OP_PART: begin
               crc   = CRC_INIT;
               count = '0;
               clear_line();
            end
            default: begin
            end
         endcase
         if (due_decodes.size() > first) due_decodes[due_decodes.size() - 1].last = 1'b1;
         if (due_decodes.size() - first == 2) pairs++;
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= SHOWN_ERRORS) $display("%0t ns  MISMATCH  %s", $time, what);
      endtask

      task match_result(logic [RSP_DATA_BITS-1:0] d, logic tl);
         rsp_item_type want;
         results++;
         if (d[73]) flagged++;
         if (due_decodes.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing due", results));
         end else begin
            want = due_decodes.pop_front();
            if (d[0] !== want.out_valid)
               report_mismatch($sformatf("result %0d out_valid %b, want %b",
                                         results, d[0], want.out_valid));
            if (d[8:1] !== want.out_byte)
               report_mismatch($sformatf("result %0d out_byte %h, want %h",
                                         results, d[8:1], want.out_byte));
            if (d[40:9] !== want.crc_value)
               report_mismatch($sformatf("result %0d crc_value %h, want %h",
                                         results, d[40:9], want.crc_value));
            if (d[72:41] !== want.decoded_count)
               report_mismatch($sformatf("result %0d decoded_count %0d, want %0d",
                                         results, d[72:41], want.decoded_count));
            if (d[73] !== want.error_code)
               report_mismatch($sformatf("result %0d error_code %b, want %b",
                                         results, d[73], want.error_code));
            if (tl !== want.last)
               report_mismatch($sformatf("result %0d last %b, want %b",
                                         results, tl, want.last));
         end
      endtask
   endclass

   // DUT signals; every input starts at a known value.
   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata   = 8'd0;   // [7:0] in_byte
   logic [1:0]               req_tuser   = 2'd0;   // [1:0] op
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;            // [0] out_valid, [8:1] out_byte,
                                                   // [40:9] crc_value,
                                                   // [72:41] decoded_count,
                                                   // [73] error_code, rest zero
   logic                     rsp_tlast;            // last
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [31:0]              csr_pwdata  = 32'd0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   // Stimulus control, owned by the main initial block.
   bit sender_idles    = 1'b0;
   bit receiver_stalls = 1'b0;
   int holds_asked     = 0;
   int sent            = 0;

   // Receiver state, owned by the receiver process.
   int holds_done = 0;
   int hold_left  = 0;
   int quiet_cycles = 0;

   yenc_crc_tracker tracker = new();

   yenc_body_decoder_crc32 uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: random stalls, plus one long hold-off on request from the stimulus.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_done < holds_asked) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_tready <= !(receiver_stalls && $urandom_range(99) < IDLE_PCT);
      end
   end

   // Result checking and the no-progress watchdog.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.match_result(rsp_tdata, rsp_tlast);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ns  watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offer one request; returns once it is accepted.
   task automatic send_request(logic [1:0] op, logic [7:0] b);
      @(negedge clock);
      if (sender_idles && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      tracker.absorb_request(op, b);
      if (op != OP_UNUSED) sent++;
   endtask

   // Stop offering, wait for every due result, then let in-flight requests finish.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.due_decodes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write dot_fix_enable over the CSR port, then read it back.
   task automatic set_dot_fix(bit v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= DOT_FIX_ADDR;
      csr_pwdata  <= {31'd0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.dot_fix = v;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== 32'(v))
         tracker.report_mismatch($sformatf("dot_fix_enable read %h, want %h",
                                           csr_prdata, 32'(v)));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One encoded line: optional leading dots, a random body, sometimes a dangling escape.
   task automatic send_line();
      int         len;
      int         r;
      logic [7:0] b;
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if ($urandom_range(99) < 30) begin
         send_request(OP_DATA, CHAR_DOT);
         if ($urandom_range(1)) send_request(OP_DATA, CHAR_DOT);
      end
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(99);
         if (r < 6)       b = CHAR_ESCAPE;
         else if (r < 9)  b = CHAR_NUL;
         else if (r < 14) b = CHAR_DOT;
         else if (r < 17) b = 8'h0d;
         else if (r < 20) b = 8'h0a;
         else             b = 8'($urandom_range(1, 255));
         send_request(OP_DATA, b);
      end
      if ($urandom_range(19) == 0) send_request(OP_DATA, CHAR_ESCAPE);
      send_request(OP_EOL, 8'($urandom_range(255)));
   endtask

   // One random phase under a given dot-fix setting and idling mode.
   task automatic run_phase(bit dot, bit idles, bit pressure);
      int  start;
      int  r;
      bit  pressed;
      set_dot_fix(dot);
      sender_idles    = idles;
      receiver_stalls = idles;
      pressed         = 1'b0;
      start           = sent;
      while (sent - start < PHASE_ITEMS) begin
         // sender keeps offering while the receiver holds off
         if (pressure && !pressed && sent - start > PHASE_ITEMS / 3) begin
            holds_asked = holds_asked + 1;
            pressed     = 1'b1;
         end
         r = $urandom_range(99);
         if (r < 3)      send_request(OP_PART, 8'($urandom_range(255)));
         else if (r < 5) send_request(OP_UNUSED, 8'($urandom_range(255)));
         send_line();
      end
      settle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed cases with the dot fix on
      set_dot_fix(1'b1);
      foreach (OPENING[i]) send_request(OPENING[i][9:8], OPENING[i][7:0]);
      settle();

      // random phases: both settings, idling, a calm stretch, one long hold-off
      run_phase(1'b0, 1'b1, 1'b0);
      run_phase(1'b1, 1'b0, 1'b0);
      run_phase(1'b0, 1'b1, 1'b1);
      run_phase(1'b1, 1'b1, 1'b0);

      $display("Run covered %0d requests and %0d results; %0d requests gave two results,",
               tracker.requests, tracker.results, tracker.pairs);
      $display("%0d escape errors flagged; dot fix on and off, idling, calm and held-off output.",
               tracker.flagged);
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", tracker.errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/ydec_pkg.sv
hdl/ydec_core.sv
hdl/ydec_rsp_queue.sv
hdl/yenc_body_decoder_crc32.sv
sim/yenc_body_decoder_crc32_tb.sv
